/* hw/rtl/chbi_pkg.sv */
// Shared constants, codes and the CRC byte fold for the CRC bucket index block.
package chbi_pkg;

  localparam int unsigned CRC_W      = 32;
  localparam int unsigned CAP_W      = 25;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = CAP_W;
  localparam int unsigned POLY_SEL_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLY_SEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_CAP = 2'd1;

  // Polynomial select codes.
  localparam logic [POLY_SEL_W-1:0] POLY_CRC32  = 2'd0;
  localparam logic [POLY_SEL_W-1:0] POLY_CRC32C = 2'd1;
  localparam logic [POLY_SEL_W-1:0] POLY_CRC32K = 2'd2;
  localparam logic [POLY_SEL_W-1:0] POLY_CRC32Q = 2'd3;

  localparam logic [CRC_W-1:0] GEN_CRC32  = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] GEN_CRC32C = 32'h1EDC_6F41;
  localparam logic [CRC_W-1:0] GEN_CRC32K = 32'h741B_8CD7;
  localparam logic [CRC_W-1:0] GEN_CRC32Q = 32'h8141_41AB;

  localparam logic [CRC_W-1:0] CRC_INIT      = 32'h0000_0000;
  localparam logic [CAP_W-1:0] CAP_RESET     = 25'd65536;

  function automatic logic [CRC_W-1:0] poly_of(input logic [POLY_SEL_W-1:0] sel);
    logic [CRC_W-1:0] poly;
    case (sel)
      POLY_CRC32:  poly = GEN_CRC32;
      POLY_CRC32C: poly = GEN_CRC32C;
      POLY_CRC32K: poly = GEN_CRC32K;
      POLY_CRC32Q: poly = GEN_CRC32Q;
      default:     poly = GEN_CRC32;
    endcase
    return poly;
  endfunction

  // Fold one byte, MSB first, into a non-reflected CRC.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [KEY_W-1:0] kbyte,
                                                 input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {kbyte, {(CRC_W-KEY_W){1'b0}}};
    for (int b = 0; b < KEY_W; b++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/chbi_mod_unit.sv */
// Bit-serial restoring remainder unit: 32-bit dividend modulo a 25-bit divisor.
module chbi_mod_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [chbi_pkg::CRC_W-1:0] dividend_i,
  input  logic [chbi_pkg::CAP_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [chbi_pkg::CAP_W-1:0] rem_o
);
  import chbi_pkg::*;

  localparam int unsigned CNT_W = $clog2(CRC_W);

  logic                 busy_q, busy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CRC_W-1:0]     num_q, num_d;
  logic [CAP_W-1:0]     div_q, div_d;
  logic [CAP_W-1:0]     rem_q, rem_d;
  logic [CAP_W:0]       trial;
  logic [CAP_W:0]       diff;

  // One shift-compare-subtract step per cycle.
  assign trial = {rem_q, num_q[CRC_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[CRC_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[CAP_W-1:0];
      end else begin
        rem_d = trial[CAP_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(CRC_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

/* hw/rtl/crc32_hash_bucket_index.sv */
// Top level of the CRC-32 hash bucket index block.
//
// Key bytes arrive one per request on the slave stream, MSB first into a
// non-reflected 32-bit CRC (init zero, no final XOR) whose generator is picked
// by poly_select. A byte without tlast is folded into the running CRC and the
// next byte is taken in the following cycle. A byte with tlast closes the key:
// the CRC is then reduced modulo table_capacity by a bit-serial remainder unit,
// one dividend bit per cycle, so the slave side stays not ready through the
// remainder steps and the step that moves the result to the output register,
// and longer if a previous result still waits there. A zero capacity acts as 1.
// Configuration writes are always taken; write them only while idle.
module crc32_hash_bucket_index #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [chbi_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [chbi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // key byte stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] key_byte
  input  logic                            s_axis_tlast,  // last_byte
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // bucket_index [INDEX_WIDTH-1:0], raw_crc above it, zero pad to bytes
  output logic [((INDEX_WIDTH+32+7)/8)*8-1:0] m_axis_tdata
);
  import chbi_pkg::*;

  localparam int unsigned OUT_W = ((INDEX_WIDTH + CRC_W + 7) / 8) * 8;
  localparam int unsigned PAD_W = OUT_W - INDEX_WIDTH - CRC_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                    state_q, state_d;
  logic [POLY_SEL_W-1:0]   poly_sel_q;
  logic [CAP_W-1:0]        cap_q;
  logic [CRC_W-1:0]        crc_q, crc_d;
  logic [CRC_W-1:0]        res_crc_q, res_crc_d;
  logic                    out_valid_q, out_valid_d;
  logic [INDEX_WIDTH-1:0]  out_idx_q, out_idx_d;
  logic [CRC_W-1:0]        out_crc_q, out_crc_d;

  logic                    in_acc;
  logic [CRC_W-1:0]        crc_fold;
  logic                    div_start;
  logic                    div_busy;
  logic [CAP_W-1:0]        div_rem;
  logic [CAP_W-1:0]        divisor;
  logic [CRC_W-1:0]        rem_wide;
  logic                    slot_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_sel_q <= POLY_CRC32;
      cap_q      <= CAP_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLY_SEL:  poly_sel_q <= cfg_data_i[POLY_SEL_W-1:0];
        REG_TABLE_CAP: cap_q      <= cfg_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign crc_fold      = fold_byte(crc_q, s_axis_tdata, poly_of(poly_sel_q));
  assign divisor       = (cap_q == '0) ? CAP_W'(1) : cap_q;
  assign div_start     = in_acc && s_axis_tlast;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign rem_wide      = {{(CRC_W-CAP_W){1'b0}}, div_rem};

  chbi_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (crc_fold),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    crc_d       = crc_q;
    res_crc_d   = res_crc_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_crc_d   = out_crc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            // clear the running CRC for the next key
            crc_d     = CRC_INIT;
            res_crc_d = crc_fold;
            state_d   = ST_DIV;
          end else begin
            crc_d = crc_fold;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy && slot_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = rem_wide[INDEX_WIDTH-1:0];
          out_crc_d   = res_crc_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_crc_q <= res_crc_d;
    out_idx_q <= out_idx_d;
    out_crc_q <= out_crc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  if (PAD_W > 0) begin : g_pad
    assign m_axis_tdata = {{PAD_W{1'b0}}, out_crc_q, out_idx_q};
  end else begin : g_nopad
    assign m_axis_tdata = {out_crc_q, out_idx_q};
  end

endmodule

/* hw/rtl/chbi_checker.sv */
// Port-level checks for the CRC bucket index block, bound to the top level.
module chbi_checker #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 s_axis_tlast,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [((INDEX_WIDTH+32+7)/8)*8-1:0]  m_axis_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A byte inside a key is folded at once; the next byte may follow.
  a_mid_key_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
    else $error("not ready after a byte inside a key");

  // The last byte of a key starts the remainder pass and blocks input.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken during the remainder pass");

endmodule

bind crc32_hash_bucket_index chbi_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_chbi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/sv/crc32_hash_bucket_index_test.sv */
// Self-checking testbench for the CRC-32 hash bucket index block.
`timescale 1ns / 1ps

module crc32_hash_bucket_index_test;
  import chbi_pkg::*;

  localparam int unsigned IDX_W         = 24;
  localparam int unsigned RES_W         = ((IDX_W + CRC_W + 7) / 8) * 8;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned PHASE_BYTES   = 667;

  // indexes with no register behind them; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // generators ordered by their select code
  localparam logic [CRC_W-1:0] GEN_BY_SEL [4] = '{GEN_CRC32, GEN_CRC32C, GEN_CRC32K, GEN_CRC32Q};

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_CFG,
    ROW_SETTLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic [KEY_W-1:0]       key;
    logic                   last;
    logic                   typed;
    logic [IDX_W-1:0]       exp_bucket;
    logic [CRC_W-1:0]       exp_crc;
  } stim_row_t;

  typedef struct packed {
    logic [IDX_W-1:0] bucket;
    logic [CRC_W-1:0] crc;
  } bucket_result_t;

  localparam stim_row_t DIRECTED_ROWS [35] = '{
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h00, 1'b1, 1'b1, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h001DB7, 32'h04C1_1DB7},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'hFF, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h80, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h5A, 1'b1, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'hFF, 1'b1, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_POLY_SEL,  25'(POLY_CRC32C), 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h006F41, 32'h1EDC_6F41},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_POLY_SEL,  25'(POLY_CRC32K), 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h008CD7, 32'h741B_8CD7},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_POLY_SEL,  25'(POLY_CRC32Q), 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h0041AB, 32'h8141_41AB},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    // zero capacity behaves as a single bucket
    '{ROW_CFG,    REG_TABLE_CAP, 25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h000000, 32'h8141_41AB},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_TABLE_CAP, 25'd1, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h01, 1'b1, 1'b1, 24'h000000, 32'h8141_41AB},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    // capacity beyond the index range: remainder gets truncated
    '{ROW_CFG,    REG_TABLE_CAP, 25'h1FFFFFF, 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'hC3, 1'b1, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_TABLE_CAP, 25'h1000000, 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_CFG,    REG_SPARE_2,   25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_SPARE_3,   25'h1FFFFFF, 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h7E, 1'b1, 1'b0, 24'h000000, 32'h0000_0000},
    // switch generator halfway through a key
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h12, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_POLY_SEL,  25'(POLY_CRC32), 8'h00, 1'b0, 1'b0, 24'h0, 32'h0},
    '{ROW_BYTE,   REG_POLY_SEL,  25'd0, 8'h34, 1'b1, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_SETTLE, REG_POLY_SEL,  25'd0, 8'h00, 1'b0, 1'b0, 24'h000000, 32'h0000_0000},
    '{ROW_CFG,    REG_TABLE_CAP, 25'(CAP_RESET), 8'h00, 1'b0, 1'b0, 24'h0, 32'h0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;   // [7:0] key_byte
  logic                  s_axis_tlast;   // last_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RES_W-1:0]      m_axis_tdata;   // [23:0] bucket_index, [55:24] raw_crc

  // predictor state
  logic [POLY_SEL_W-1:0] poly_sel_q;
  logic [CAP_W-1:0]      capacity_q;
  logic [CRC_W-1:0]      crc_acc;
  bucket_result_t        pending_results[$];

  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int unsigned mismatch_count;
  int unsigned byte_count;
  int unsigned result_count;
  int unsigned cfg_write_count;

  crc32_hash_bucket_index #(
    .INDEX_WIDTH(IDX_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // MSB-first shift: feedback is the outgoing top bit XOR the incoming data bit
  function automatic logic [CRC_W-1:0] crc_shift_byte(input logic [CRC_W-1:0] crc,
                                                      input logic [KEY_W-1:0] kbyte,
                                                      input logic [CRC_W-1:0] gen);
    logic [CRC_W-1:0] r;
    logic             fb;
    r = crc;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      fb = r[CRC_W-1] ^ kbyte[i];
      r  = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
        r = r ^ gen;
      end
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] bucket_of(input logic [CRC_W-1:0] crc,
                                                 input logic [CAP_W-1:0] cap);
    logic [CRC_W-1:0] divisor;
    logic [CRC_W-1:0] rem;
    divisor = (cap == '0) ? 32'd1 : 32'(cap);
    rem     = crc % divisor;
    return rem[IDX_W-1:0];
  endfunction

  function automatic logic [CAP_W-1:0] pick_capacity();
    logic [CAP_W-1:0] cap;
    case ($urandom_range(7))
      0:       cap = '0;
      1:       cap = 25'd1;
      2:       cap = 25'h1000000;
      3:       cap = 25'h1FFFFFF;
      4:       cap = 25'($urandom_range(2, 255));
      5:       cap = CAP_RESET;
      6:       cap = 25'($urandom_range(256, 16777216));
      default: cap = 25'($urandom);
    endcase
    return cap;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_POLY_SEL) begin
      poly_sel_q = data[POLY_SEL_W-1:0];
    end else if (idx == REG_TABLE_CAP) begin
      capacity_q = data;
    end
    cfg_write_count++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // typed_exp overrides the predictor for rows whose result is known by hand
  task automatic send_key_byte(input logic [KEY_W-1:0] kbyte, input logic last,
                               input logic typed, input bucket_result_t typed_exp);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = kbyte;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    crc_acc = crc_shift_byte(crc_acc, kbyte, GEN_BY_SEL[poly_sel_q]);
    byte_count++;
    if (last) begin
      if (typed) begin
        pending_results.push_back(typed_exp);
      end else begin
        pending_results.push_back(
          bucket_result_t'{bucket: bucket_of(crc_acc, capacity_q), crc: crc_acc});
      end
      crc_acc = CRC_INIT;
    end
  endtask

  // drop valid, wait for every result, then let the remainder unit go quiet
  task automatic drain_and_settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned key_len;
    for (int s = 0; s < 4; s++) begin
      drain_and_settle();
      write_register(REG_POLY_SEL, 25'($urandom));
      write_register(REG_TABLE_CAP, pick_capacity());
      if ($urandom_range(3) == 0) begin
        write_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 25'($urandom));
      end
      sent = 0;
      while (sent < n_bytes / 4) begin
        key_len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        for (int i = 0; i < key_len; i++) begin
          send_key_byte(8'($urandom), i == key_len - 1, 1'b0, '0);
        end
        sent += key_len;
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk_i) begin
    bucket_result_t got;
    bucket_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.bucket = m_axis_tdata[IDX_W-1:0];
      got.crc    = m_axis_tdata[IDX_W+CRC_W-1:IDX_W];
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result crc=%h bucket=%h", got.crc, got.bucket));
      end else begin
        want = pending_results.pop_front();
        if (got.bucket !== want.bucket) begin
          report_mismatch($sformatf("bucket_index %h, want %h", got.bucket, want.bucket));
        end
        if (got.crc !== want.crc) begin
          report_mismatch($sformatf("raw_crc %h, want %h", got.crc, want.crc));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    poly_sel_q      = POLY_CRC32;
    capacity_q      = CAP_RESET;
    crc_acc         = CRC_INIT;
    mismatch_count  = 0;
    byte_count      = 0;
    result_count    = 0;
    cfg_write_count = 0;
    src_idle_pct    = 36;
    dst_idle_pct    = 53;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      row = DIRECTED_ROWS[r];
      case (row.kind)
        ROW_BYTE: begin
          send_key_byte(row.key, row.last, row.typed,
                        '{bucket: row.exp_bucket, crc: row.exp_crc});
        end
        ROW_CFG: begin
          write_register(row.cfg_idx, row.cfg_data);
        end
        default: begin
          drain_and_settle();
        end
      endcase
    end

    run_random_phase(PHASE_BYTES);
    src_idle_pct = 53;
    dst_idle_pct = 36;
    run_random_phase(PHASE_BYTES);
    src_idle_pct = 0;
    dst_idle_pct = 0;
    run_random_phase(PHASE_BYTES);
    drain_and_settle();

    $display("covered %0d key bytes, %0d bucket results, %0d register writes",
             byte_count, result_count, cfg_write_count);
    $display("all four generators, capacities from zero past the index range, mixed stalls");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
